// ===== rtl/htsed_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsed_pkg
// Types, candidate patterns and the candidate match function shared by the
// tag stripper / entity decoder modules.
// ----------------------------------------------------------------------------
package htsed_pkg;

	localparam int PEND_DEPTH = 6;
	localparam int NUM_PAT    = 8;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_in;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_out;
	} out_t;

	typedef logic [PEND_DEPTH-1:0][7:0] pend_t;

	// candidate kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_BR   = 2'd1;
	localparam logic [1:0] KIND_ENT  = 2'd2;

	// candidate extension outcome
	localparam logic [1:0] EXT_FAIL   = 2'd0;
	localparam logic [1:0] EXT_PREFIX = 2'd1;
	localparam logic [1:0] EXT_DONE   = 2'd2;

	// byte source selects for the datapath
	localparam logic [1:0] SRC_IN   = 2'd0;
	localparam logic [1:0] SRC_CUR  = 2'd1;
	localparam logic [1:0] SRC_PEND = 2'd2;

	localparam logic [7:0] CH_LT  = 8'h3C;
	localparam logic [7:0] CH_GT  = 8'h3E;
	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;

	localparam logic [7:0] PAT [NUM_PAT][PEND_DEPTH] = '{
		'{"&", "a", "m", "p", ";", 8'h00},
		'{"&", "g", "t", ";", 8'h00, 8'h00},
		'{"&", "l", "t", ";", 8'h00, 8'h00},
		'{"&", "n", "b", "s", "p", ";"},
		'{"&", "a", "p", "o", "s", ";"},
		'{"&", "q", "u", "o", "t", ";"},
		'{"<", "b", "r", 8'h00, 8'h00, 8'h00},
		'{"<", "B", "R", 8'h00, 8'h00, 8'h00}
	};
	localparam logic [2:0] PAT_LEN [NUM_PAT] = '{
		3'd5, 3'd4, 3'd4, 3'd6, 3'd6, 3'd6, 3'd3, 3'd3
	};
	localparam logic [7:0] PAT_VAL [NUM_PAT] = '{
		8'h26, 8'h3E, 8'h3C, 8'h20, 8'h27, 8'h22, 8'h0A, 8'h0A
	};
	localparam logic [1:0] PAT_KIND [NUM_PAT] = '{
		KIND_ENT, KIND_ENT, KIND_ENT, KIND_ENT, KIND_ENT, KIND_ENT,
		KIND_BR, KIND_BR
	};

	typedef struct packed {
		logic [1:0] res;
		logic [7:0] val;
	} ext_t;

	typedef struct packed {
		logic       step;
		logic [1:0] src;
		logic       load_cur;
		logic       inc_rix;
		logic       clr_cnt;
		logic       flush;
		logic       term;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic fail;
		logic busy;
		logic rix_done;
		logic ended;
		logic cur_last;
		logic in_zero;
		logic in_last;
	} stat_t;

	// Try to extend the held candidate (pos bytes in pend) with byte c.
	function automatic ext_t extend(input logic [1:0] kind, input logic [2:0] pos,
			input pend_t pend, input logic [7:0] c);
		ext_t r;
		logic ok;
		logic hit;
		r.res = EXT_FAIL;
		r.val = 8'h00;
		for (int k = 0; k < NUM_PAT; k++) begin
			ok = (PAT_KIND[k] == kind) && (pos < PAT_LEN[k]);
			hit = 1'b0;
			for (int i = 0; i < PEND_DEPTH; i++) begin
				if ((3'(i) < pos) && (PAT[k][i] != pend[i]))
					ok = 1'b0;
				if ((3'(i) == pos) && (PAT[k][i] == c))
					hit = 1'b1;
			end
			if (ok && hit) begin
				if (({1'b0, pos} + 4'd1) == {1'b0, PAT_LEN[k]}) begin
					r.res = EXT_DONE;
					r.val = PAT_VAL[k];
				end else if (r.res != EXT_DONE) begin
					r.res = EXT_PREFIX;
				end
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/htsed_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsed_dp
// Datapath: mode flags, held candidate bytes, replay index, deferred byte and
// the output register.
// ----------------------------------------------------------------------------
module htsed_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  htsed_pkg::in_t  in_data,
	input  logic            out_ready,
	output logic            out_valid,
	output htsed_pkg::out_t out_data,
	input  htsed_pkg::cmd_t cmd,
	output htsed_pkg::stat_t stat
);

	logic               in_tag_q;
	logic [1:0]         kind_q;
	logic [2:0]         cnt_q;
	logic [2:0]         rix_q;
	logic               ended_q;
	htsed_pkg::pend_t   pend_q;
	logic [7:0]         cur_q;
	logic               cur_last_q;
	logic               out_valid_q;
	htsed_pkg::out_t    out_q;

	logic [7:0]         c;
	logic               busy;
	htsed_pkg::ext_t    ext;
	logic               ev_emit;
	logic [7:0]         ev_byte;
	logic               ev_fail;
	logic               emit_any;
	htsed_pkg::out_t    emit_data;
	logic               pw_en;
	logic [2:0]         pw_addr;

	always_comb begin
		case (cmd.src)
			htsed_pkg::SRC_IN:   c = in_data.in_byte;
			htsed_pkg::SRC_CUR:  c = cur_q;
			htsed_pkg::SRC_PEND: c = pend_q[rix_q];
			default:             c = in_data.in_byte;
		endcase
	end

	assign busy = (kind_q != htsed_pkg::KIND_NONE);
	assign ext  = htsed_pkg::extend(kind_q, cnt_q, pend_q, c);

	always_comb begin
		ev_emit = 1'b0;
		ev_byte = c;
		ev_fail = 1'b0;
		pw_en   = 1'b0;
		pw_addr = cnt_q;
		if (busy) begin
			if (ext.res == htsed_pkg::EXT_DONE) begin
				ev_emit = 1'b1;
				ev_byte = ext.val;
			end else if (ext.res == htsed_pkg::EXT_PREFIX) begin
				pw_en = cmd.step;
			end else begin
				ev_fail = 1'b1;
				ev_emit = (kind_q == htsed_pkg::KIND_ENT);
				ev_byte = htsed_pkg::CH_AMP;
			end
		end else if (c == htsed_pkg::CH_LT || c == htsed_pkg::CH_AMP) begin
			pw_en   = cmd.step;
			pw_addr = 3'd0;
		end else if (c != htsed_pkg::CH_GT) begin
			ev_emit = !in_tag_q && c != htsed_pkg::CH_CR && c != htsed_pkg::CH_LF;
		end
	end

	always_comb begin
		emit_any           = 1'b0;
		emit_data.out_byte = ev_byte;
		emit_data.last_out = 1'b0;
		if (cmd.step && ev_emit) begin
			emit_any = 1'b1;
		end else if (cmd.flush && kind_q == htsed_pkg::KIND_ENT) begin
			emit_any           = 1'b1;
			emit_data.out_byte = htsed_pkg::CH_AMP;
		end else if (cmd.term) begin
			emit_any           = 1'b1;
			emit_data.out_byte = 8'h00;
			emit_data.last_out = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tag_q    <= 1'b0;
			kind_q      <= htsed_pkg::KIND_NONE;
			cnt_q       <= 3'd0;
			rix_q       <= 3'd0;
			ended_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_cnt)
				cnt_q <= 3'd0;
			if (cmd.inc_rix)
				rix_q <= rix_q + 3'd1;
			if (cmd.step) begin
				if (busy) begin
					if (ext.res == htsed_pkg::EXT_DONE) begin
						kind_q <= htsed_pkg::KIND_NONE;
						cnt_q  <= 3'd0;
					end else if (ext.res == htsed_pkg::EXT_PREFIX) begin
						cnt_q <= cnt_q + 3'd1;
					end else begin
						// held bytes after the lead character get replayed
						kind_q <= htsed_pkg::KIND_NONE;
						rix_q  <= 3'd1;
					end
				end else if (c == htsed_pkg::CH_LT) begin
					in_tag_q <= 1'b1;
					kind_q   <= htsed_pkg::KIND_BR;
					cnt_q    <= 3'd1;
				end else if (c == htsed_pkg::CH_AMP) begin
					kind_q <= htsed_pkg::KIND_ENT;
					cnt_q  <= 3'd1;
				end else if (c == htsed_pkg::CH_GT) begin
					in_tag_q <= 1'b0;
				end
			end
			if (cmd.flush) begin
				kind_q <= htsed_pkg::KIND_NONE;
				rix_q  <= 3'd1;
			end
			if (cmd.term)
				ended_q <= 1'b1;
			if (emit_any)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pw_en)
			pend_q[pw_addr] <= c;
		if (cmd.load_cur) begin
			cur_q      <= in_data.in_byte;
			cur_last_q <= in_data.last_in;
		end
		if (emit_any)
			out_q <= emit_data;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.fail     = ev_fail;
	assign stat.busy     = busy;
	assign stat.rix_done = (rix_q >= cnt_q);
	assign stat.ended    = ended_q;
	assign stat.cur_last = cur_last_q;
	assign stat.in_zero  = (in_data.in_byte == 8'h00);
	assign stat.in_last  = in_data.last_in;

endmodule

// ===== rtl/htsed_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsed_ctrl
// Controller: sequences input steps, candidate replay, end-of-text flush and
// the terminator result.
// ----------------------------------------------------------------------------
module htsed_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output htsed_pkg::cmd_t  cmd,
	input  htsed_pkg::stat_t stat
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PROC  = 3'd1;
	localparam logic [2:0] ST_RPLY  = 3'd2;
	localparam logic [2:0] ST_FLUSH = 3'd3;
	localparam logic [2:0] ST_TERM  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rply_to_flush_q;
	logic       rply_to_flush_d;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE) && stat.out_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd             = '0;
		cmd.src         = htsed_pkg::SRC_IN;
		state_d         = state_q;
		rply_to_flush_d = rply_to_flush_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !stat.ended) begin
					cmd.load_cur = 1'b1;
					if (stat.in_zero) begin
						state_d = ST_FLUSH;
					end else begin
						cmd.step = 1'b1;
						if (stat.fail) begin
							rply_to_flush_d = 1'b0;
							state_d         = ST_RPLY;
						end else if (stat.in_last) begin
							state_d = ST_FLUSH;
						end
					end
				end
			end
			ST_PROC: begin
				cmd.src = htsed_pkg::SRC_CUR;
				if (stat.out_free) begin
					cmd.step = 1'b1;
					state_d  = stat.cur_last ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_RPLY: begin
				cmd.src = htsed_pkg::SRC_PEND;
				if (stat.rix_done) begin
					cmd.clr_cnt = 1'b1;
					state_d     = rply_to_flush_q ? ST_FLUSH : ST_PROC;
				end else if (stat.out_free) begin
					cmd.step    = 1'b1;
					cmd.inc_rix = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (!stat.busy) begin
					state_d = ST_TERM;
				end else if (stat.out_free) begin
					cmd.flush       = 1'b1;
					rply_to_flush_d = 1'b1;
					state_d         = ST_RPLY;
				end
			end
			ST_TERM: begin
				if (stat.out_free) begin
					cmd.term = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			rply_to_flush_q <= 1'b0;
		end else begin
			rply_to_flush_q <= rply_to_flush_d;
			state_q         <= state_d;
		end
	end

endmodule

// ===== rtl/html_tag_strip_entity_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_tag_strip_entity_decode
// Byte-stream HTML tag stripper with entity and line-break decoding.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one text byte per transaction; last_in
//   marks the final byte, and a zero byte ends the text as well.
//   out_valid/out_ready/out_data carry the filtered bytes; the text closes
//   with a zero byte flagged last_out.
// Throughput and sequencing:
//   A plain byte is taken when in_ready is high and its result sits in the
//   output register the next cycle, so plain text streams at one byte per
//   cycle while out_ready keeps the output register free.
//   A failed '<' or '&' candidate replays each held byte after the lead
//   character, closes the replay, then handles the deferred byte; no input
//   is taken meanwhile. At end of text an open candidate is dropped and its
//   held bytes after the lead character replayed before the terminator.
// Reset clears tag mode, the open candidate and the end-of-text flag.
// After the terminator all further input is taken and dropped until reset.
// in_ready stays low while the output register holds a result that
// out_ready has not yet taken; nothing is lost or repeated under a stall.
// ----------------------------------------------------------------------------
module html_tag_strip_entity_decode (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  htsed_pkg::in_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output htsed_pkg::out_t out_data
);

	htsed_pkg::cmd_t  cmd;
	htsed_pkg::stat_t stat;

	htsed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	htsed_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
